// ===== rtl/core/sbh_pkg.sv =====
// Shared types, constants and helper functions for the string bucket hash.
package sbh_pkg;

	localparam int LENGTH_BITS = 32;

	localparam logic [31:0] MM_C1      = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2      = 32'h1b873593;
	localparam logic [31:0] MM_N       = 32'he6546b64;
	localparam logic [31:0] MM_F1      = 32'h85ebca6b;
	localparam logic [31:0] MM_F2      = 32'hc2b2ae35;
	localparam logic [31:0] MM_ROW_MUL = 32'd5;
	localparam logic [31:0] CLASSIC_MUL = 32'd33;
	localparam logic [16:0] BUCKET_MOD = 17'h0FFF1;
	localparam logic [16:0] FOLD_MUL   = 17'd15;

	// Configuration register indexes
	localparam logic [0:0] CFG_USE_MURMUR = 1'b0;
	localparam logic [0:0] CFG_HASH_SEED  = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       empty_string;
	} item_t;

	typedef struct packed {
		logic [31:0] raw_hash;
		logic [15:0] bucket;
	} result_t;

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

	function automatic logic [31:0] rotl13(input logic [31:0] x);
		return {x[18:0], x[31:19]};
	endfunction

	// 2^16 is 15 modulo 65521: fold the high half down once
	function automatic logic [19:0] fold_once(input logic [31:0] x);
		return 20'(x[31:16]) * 20'd15 + 20'(x[15:0]);
	endfunction

	// Second fold leaves a value below twice the modulus; one subtract ends it
	function automatic logic [15:0] fold_final(input logic [19:0] x);
		logic [16:0] s;
		s = 17'(x[19:16]) * FOLD_MUL + 17'(x[15:0]);
		if (s >= BUCKET_MOD) begin
			return 16'(s - BUCKET_MOD);
		end
		return 16'(s);
	endfunction

endpackage

// ===== rtl/core/string_bucket_hash.sv =====
// Top level: configuration registers, hash sequencer and result register.
// Per request: in multiply-by-33 mode each byte is dispatched, then added to the product;
// in murmur mode a byte is gathered at dispatch, and every fourth byte runs the word mix
// of three products. A request that ends a string then forms the result, in murmur mode
// after the tail scramble and two finalization products; an empty-string request skips
// the byte step. A stalled, full result register holds the last step.
// All multiplies share one registered 32x32 multiplier. Reset (arst_n low, asynchronous)
// clears the sequencer, the string state and the configuration.
module string_bucket_hash
	import sbh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic        use_murmur_q;
	logic [31:0] hash_seed_q;
	logic        result_valid_q;
	result_t     result_q;
	logic        out_free;
	logic        seq_done;
	result_t     seq_result;

	// Config writes never stall; a string latches mode and seed on its first request,
	// so a write lands in the next string.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_murmur_q <= 1'b0;
			hash_seed_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_USE_MURMUR: use_murmur_q <= cfg_data[0];
				CFG_HASH_SEED:  hash_seed_q  <= cfg_data;
				default:        use_murmur_q <= use_murmur_q;
			endcase
		end
	end

	// The result register frees up when empty or when its result is taken,
	// so the sequencer keeps accepting bytes while a result waits.
	assign out_free = !result_valid_q || !result_stall;

	sbh_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.use_murmur (use_murmur_q),
		.hash_seed  (hash_seed_q),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.out_free   (out_free),
		.done       (seq_done),
		.result     (seq_result)
	);

	// Hold the result while stalled, load a new one when the sequencer finishes,
	// drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (seq_done) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			result_q <= seq_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/core/sbh_mul.sv =====
// Shared 32x32 multiplier, low product word registered.
module sbh_mul
	import sbh_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [31:0] product
);

	logic [31:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= op_a * op_b;
	end

	assign product = product_q;

endmodule

// ===== rtl/core/sbh_seq.sv =====
// Sequencer and datapath: per-byte hash update, finalization and bucket reduction.
module sbh_seq
	import sbh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        use_murmur,
	input  logic [31:0] hash_seed,
	input  logic        item_valid,
	input  item_t       item,
	output logic        item_stall,
	input  logic        out_free,
	output logic        done,
	output result_t     result
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DISPATCH = 4'd1;
	localparam logic [3:0] ST_K2       = 4'd2;
	localparam logic [3:0] ST_MIX      = 4'd3;
	localparam logic [3:0] ST_ADDN     = 4'd4;
	localparam logic [3:0] ST_C_ADD    = 4'd5;
	localparam logic [3:0] ST_FIN      = 4'd6;
	localparam logic [3:0] ST_F_K2     = 4'd7;
	localparam logic [3:0] ST_F_TAIL   = 4'd8;
	localparam logic [3:0] ST_F_M2     = 4'd9;
	localparam logic [3:0] ST_F_END    = 4'd10;
	localparam logic [3:0] ST_MOD1     = 4'd11;
	localparam logic [3:0] ST_MOD2     = 4'd12;

	logic [3:0]             state_q;
	logic                   in_string_q;
	logic                   mode_q;
	logic [31:0]            hash_q;
	logic [23:0]            gather_q;
	logic [1:0]             phase_q;
	logic [LENGTH_BITS-1:0] len_q;
	item_t                  item_q;
	logic [31:0]            raw_q;
	logic [19:0]            red_q;

	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] mul_q;
	logic [31:0] tail_t0;
	logic [31:0] tail_t1;
	logic [31:0] mid_t;

	sbh_mul u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.product (mul_q)
	);

	assign tail_t0 = hash_q ^ ((phase_q != 2'd0) ? mul_q : 32'd0) ^ 32'(len_q);
	assign tail_t1 = tail_t0 ^ (tail_t0 >> 16);
	assign mid_t   = mul_q ^ (mul_q >> 13);

	always_comb begin
		op_a = hash_q;
		op_b = CLASSIC_MUL;
		unique case (state_q)
			ST_DISPATCH: begin
				if (mode_q) begin
					op_a = {item_q.data_byte, gather_q};
					op_b = MM_C1;
				end
			end
			ST_K2, ST_F_K2: begin
				op_a = rotl15(mul_q);
				op_b = MM_C2;
			end
			ST_MIX: begin
				op_a = rotl13(hash_q ^ mul_q);
				op_b = MM_ROW_MUL;
			end
			ST_FIN: begin
				op_a = {8'd0, gather_q};
				op_b = MM_C1;
			end
			ST_F_TAIL: begin
				op_a = tail_t1;
				op_b = MM_F1;
			end
			ST_F_M2: begin
				op_a = mid_t;
				op_b = MM_F2;
			end
			default: begin
				op_a = hash_q;
				op_b = CLASSIC_MUL;
			end
		endcase
	end

	assign item_stall = (state_q != ST_IDLE);
	assign done       = (state_q == ST_MOD2) && out_free;
	assign result     = '{raw_hash: raw_q, bucket: fold_final(red_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_string_q <= 1'b0;
			mode_q      <= 1'b0;
			hash_q      <= '0;
			gather_q    <= '0;
			phase_q     <= '0;
			len_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (!in_string_q) begin
							mode_q      <= use_murmur;
							hash_q      <= use_murmur ? hash_seed : 32'd0;
							gather_q    <= '0;
							phase_q     <= '0;
							len_q       <= '0;
							in_string_q <= 1'b1;
						end
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (item_q.empty_string) begin
						state_q <= ST_FIN;
					end else begin
						len_q <= len_q + LENGTH_BITS'(1);
						if (!mode_q) begin
							state_q <= ST_C_ADD;
						end else if (phase_q == 2'd3) begin
							state_q <= ST_K2;
						end else begin
							unique case (phase_q)
								2'd0: gather_q[7:0]   <= item_q.data_byte;
								2'd1: gather_q[15:8]  <= item_q.data_byte;
								default: gather_q[23:16] <= item_q.data_byte;
							endcase
							phase_q <= phase_q + 2'd1;
							state_q <= item_q.last_byte ? ST_FIN : ST_IDLE;
						end
					end
				end
				ST_K2: state_q <= ST_MIX;
				ST_MIX: state_q <= ST_ADDN;
				ST_ADDN: begin
					hash_q   <= mul_q + MM_N;
					gather_q <= '0;
					phase_q  <= '0;
					state_q  <= item_q.last_byte ? ST_FIN : ST_IDLE;
				end
				ST_C_ADD: begin
					hash_q  <= mul_q + {{24{item_q.data_byte[7]}}, item_q.data_byte};
					state_q <= item_q.last_byte ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					state_q <= mode_q ? ST_F_K2 : ST_MOD1;
				end
				ST_F_K2: state_q <= ST_F_TAIL;
				ST_F_TAIL: state_q <= ST_F_M2;
				ST_F_M2: state_q <= ST_F_END;
				ST_F_END: state_q <= ST_MOD1;
				ST_MOD1: state_q <= ST_MOD2;
				ST_MOD2: begin
					if (out_free) begin
						in_string_q <= 1'b0;
						hash_q      <= '0;
						gather_q    <= '0;
						phase_q     <= '0;
						len_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: request capture, raw hash and first fold
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			item_q <= item;
		end
		if (state_q == ST_FIN && !mode_q) begin
			raw_q <= hash_q;
		end
		if (state_q == ST_F_END) begin
			raw_q <= mul_q ^ (mul_q >> 16);
		end
		if (state_q == ST_MOD1) begin
			red_q <= fold_once(raw_q);
		end
	end

endmodule

// ===== rtl/core/sbh_checker.sv =====
// Port-level checker for the string bucket hash, bound to the top level.
module sbh_checker
	import sbh_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input result_t     result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.bucket < 16'hFFF1)
		else $error("bucket not reduced below modulus");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("block took a request without going busy");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without sequencer activity");

endmodule

bind string_bucket_hash sbh_checker u_sbh_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for string_bucket_hash: directed table, then random strings.
module tb_top;
	import sbh_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [0:0] {
		ROW_ITEM = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_e;

	// One directed step: either a register write or a request; a request row may
	// carry a hand-computed result that replaces the predicted one.
	typedef struct packed {
		row_kind_e   kind;
		logic [0:0]  reg_idx;
		logic [31:0] reg_val;
		item_t       req;
		logic        typed;
		result_t     want;
	} stim_row_t;

	localparam int N_DIR = 29;
	// Drain time before a register write: worst request (murmur word) plus margin
	localparam int SETTLE_CYCLES = 16;
	localparam int ITEMS_PER_PHASE = 467;
	localparam int CFG_EVERY = 120;

	// Directed walk: classic extremes and sign extension, empty handling, murmur
	// empty string, word plus tail, mode change mid-string, empty flag mid-string.
	localparam stim_row_t DIR_TAB [N_DIR] = '{
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{32'h0000_0000, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'hFF, 1'b1, 1'b0}, 1'b1, '{32'hFFFF_FFFF, 16'd224}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h80, 1'b1, 1'b0}, 1'b1, '{32'hFFFF_FF80, 16'd97}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h7F, 1'b1, 1'b0}, 1'b1, '{32'h0000_007F, 16'd127}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h00, 1'b1, 1'b0}, 1'b1, '{32'h0000_0000, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h61, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h62, 1'b1, 1'b0}, 1'b1, '{32'h0000_0CE3, 16'd3299}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h41, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'hAA, 1'b1, 1'b1}, 1'b1, '{32'h0000_0041, 16'd65}},
		'{ROW_CFG,  CFG_USE_MURMUR, 32'h1, '{8'h00, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{32'h0000_0000, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h00, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h01, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h02, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h03, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'hFF, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h80, 1'b1, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h10, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_CFG,  CFG_USE_MURMUR, 32'h0, '{8'h00, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_CFG,  CFG_HASH_SEED,  32'hFFFF_FFFF, '{8'h00, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h20, 1'b1, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'hC3, 1'b0, 1'b1}, 1'b1, '{32'h0000_0000, 16'd0}},
		'{ROW_CFG,  CFG_USE_MURMUR, 32'h1, '{8'h00, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'hFF, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'hFF, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'hFF, 1'b1, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h55, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h66, 1'b0, 1'b0}, 1'b0, '{32'h0, 16'd0}},
		'{ROW_ITEM, CFG_USE_MURMUR, 32'h0, '{8'h00, 1'b0, 1'b1}, 1'b0, '{32'h0, 16'd0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Bench copy of the registers and of the string state
	logic        reg_murmur;
	logic [31:0] reg_seed;
	logic        str_open;
	logic        str_murmur;
	logic [31:0] str_hash;
	logic [31:0] str_gather;
	logic [1:0]  str_phase;
	logic [31:0] str_len;

	result_t hash_due [$];

	int gap_pct;
	int stall_pct;
	int n_fail;
	int n_req;
	int n_strings;
	int n_murmur;
	int n_checked;
	int n_cfg;

	string_bucket_hash u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Murmur word scramble: multiply, rotate left 15, multiply
	function automatic logic [31:0] scramble(input logic [31:0] k);
		logic [31:0] t;
		t = k * MM_C1;
		t = {t[16:0], t[31:17]};
		return t * MM_C2;
	endfunction

	// Close the string: tail word, length, avalanche; classic mode passes through
	function automatic logic [31:0] close_hash(input logic murmur, input logic [31:0] h0,
			input logic [31:0] gather, input logic [1:0] phase, input logic [31:0] len);
		logic [31:0] h;
		h = h0;
		if (!murmur) begin
			return h;
		end
		if (phase != 2'd0) begin
			h ^= scramble(gather);
		end
		h ^= len;
		h ^= h >> 16;
		h = h * MM_F1;
		h ^= h >> 13;
		h = h * MM_F2;
		h ^= h >> 16;
		return h;
	endfunction

	// Advance the string state by one request; report the bucket when it ends
	task automatic hash_request(input item_t x, output bit ends, output result_t r);
		logic [31:0] sb;
		logic [31:0] len_mask;
		len_mask = 32'((64'd1 << LENGTH_BITS) - 64'd1);
		if (!str_open) begin
			str_murmur = reg_murmur;
			str_hash   = reg_murmur ? reg_seed : 32'd0;
			str_gather = '0;
			str_phase  = '0;
			str_len    = '0;
			str_open   = 1'b1;
		end
		if (!x.empty_string) begin
			if (str_murmur) begin
				if (str_phase == 2'd3) begin
					str_hash ^= scramble({x.data_byte, str_gather[23:0]});
					str_hash = {str_hash[18:0], str_hash[31:19]};
					str_hash = str_hash * MM_ROW_MUL + MM_N;
					str_gather = '0;
					str_phase  = '0;
				end else begin
					str_gather |= 32'(x.data_byte) << (8 * str_phase);
					str_phase = str_phase + 2'd1;
				end
			end else begin
				sb = {{24{x.data_byte[7]}}, x.data_byte};
				str_hash = sb + CLASSIC_MUL * str_hash;
			end
			str_len = (str_len + 32'd1) & len_mask;
		end
		ends = x.empty_string || x.last_byte;
		r = '0;
		if (ends) begin
			r.raw_hash = close_hash(str_murmur, str_hash, str_gather, str_phase, str_len);
			r.bucket = 16'(r.raw_hash % 32'(BUCKET_MOD));
			n_strings++;
			if (str_murmur) begin
				n_murmur++;
			end
			str_open   = 1'b0;
			str_hash   = '0;
			str_gather = '0;
			str_phase  = '0;
			str_len    = '0;
		end
	endtask

	// Send one request; enter and leave at a falling edge. A typed result, when
	// given, stands in for the predicted one.
	task automatic send_req(input item_t x, input bit typed, input result_t want);
		bit      ends;
		result_t r;
		while ($urandom_range(99) < gap_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item = x;
		do begin
			@(posedge clk);
		end while (item_stall);
		n_req++;
		hash_request(x, ends, r);
		if (ends) begin
			hash_due.insert(hash_due.size(), typed ? want : r);
		end
		@(negedge clk);
	endtask

	// Write a register only once the block has gone quiet
	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		item_valid = 1'b0;
		while (hash_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		if (idx == CFG_USE_MURMUR) begin
			reg_murmur = val[0];
		end else begin
			reg_seed = val;
		end
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Pick a new setting: random mode, and often a seed at an extreme or random
	task automatic shuffle_regs();
		int pick;
		write_reg(CFG_USE_MURMUR, 32'($urandom_range(1)));
		if ($urandom_range(1) == 1) begin
			pick = $urandom_range(2);
			write_reg(CFG_HASH_SEED, (pick == 0) ? 32'h0 :
					(pick == 1) ? 32'hFFFF_FFFF : 32'($urandom));
		end
	endtask

	// One random string: mostly short, some long, ended by last, by an empty
	// request, or by both flags at once; now and then a write lands mid-string.
	task automatic send_string();
		int     len;
		int     ending;
		int     mid_cfg;
		item_t  x;
		len = $urandom_range(99);
		len = (len < 5) ? 0 : (len < 85) ? $urandom_range(12, 1) : $urandom_range(48, 13);
		ending = $urandom_range(99);
		mid_cfg = ($urandom_range(99) < 4) ? len / 2 : -1;
		if (len == 0) begin
			x = '{8'($urandom), 1'($urandom), 1'b1};
			send_req(x, 1'b0, '0);
			return;
		end
		for (int i = 0; i < len; i++) begin
			if (i == mid_cfg && i != 0) begin
				shuffle_regs();
			end
			x = '{8'($urandom), 1'b0, 1'b0};
			if (i == len - 1 && ending < 78) begin
				x.last_byte = 1'b1;
			end
			send_req(x, 1'b0, '0);
		end
		if (ending >= 78) begin
			// Terminate with an empty request; data is don't-care
			x = '{8'($urandom), (ending >= 90), 1'b1};
			send_req(x, 1'b0, '0);
		end
	endtask

	// Result side: draw stall at the falling edge, check at the rising edge
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (hash_due.size() == 0) begin
				$error("unexpected result: raw_hash %h bucket %0d", result.raw_hash,
						result.bucket);
				n_fail++;
			end else begin
				want = hash_due.pop_front();
				n_checked++;
				if (result.raw_hash !== want.raw_hash) begin
					$error("raw_hash: expected %h, got %h", want.raw_hash, result.raw_hash);
					n_fail++;
				end
				if (result.bucket !== want.bucket) begin
					$error("bucket: expected %0d, got %0d", want.bucket, result.bucket);
					n_fail++;
				end
			end
		end
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int target;
		int next_cfg;
		reg_murmur = 1'b0;
		reg_seed   = '0;
		str_open   = 1'b0;
		str_murmur = 1'b0;
		str_hash   = '0;
		str_gather = '0;
		str_phase  = '0;
		str_len    = '0;
		gap_pct    = 19;
		stall_pct  = 73;
		n_fail     = 0;
		n_req      = 0;
		n_strings  = 0;
		n_murmur   = 0;
		n_checked  = 0;
		n_cfg      = 0;

		// Hold reset, then release it at a falling edge
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table
		for (int i = 0; i < N_DIR; i++) begin
			if (DIR_TAB[i].kind == ROW_CFG) begin
				write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].reg_val);
			end else begin
				send_req(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].want);
			end
		end

		// Random strings in three idling phases: sender light / receiver heavy,
		// then swapped, then no idling at all
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct   = (ph == 0) ? 19 : (ph == 1) ? 73 : 0;
			stall_pct = (ph == 0) ? 73 : (ph == 1) ? 19 : 0;
			shuffle_regs();
			target = n_req + ITEMS_PER_PHASE;
			next_cfg = n_req + CFG_EVERY;
			while (n_req < target) begin
				if (n_req >= next_cfg) begin
					shuffle_regs();
					next_cfg = n_req + CFG_EVERY;
				end
				send_string();
			end
		end

		// Drop valid, drain what is still owed, then let the pipe settle
		item_valid = 1'b0;
		while (hash_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4 * SETTLE_CYCLES) @(negedge clk);

		$display("ran %0d requests and %0d register writes", n_req, n_cfg);
		$display("hashed %0d strings (%0d murmur), checked %0d results", n_strings,
				n_murmur, n_checked);
		if (n_fail == 0 && hash_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
